// ===== rtl/hsec_pkg.sv =====
package hsec_pkg;

    localparam int DATA_W   = 57;
    localparam int CODE_W   = 63;
    localparam int LEN_W    = 6;
    localparam int POS_W    = 6;
    localparam int CHK_W    = 3;
    localparam int DATA_MAX = 57;
    localparam int ADDR_W   = 3;
    localparam int PDATA_W  = 32;

    localparam logic [LEN_W-1:0] DATA_LENGTH_RST = LEN_W'(4);

    // register index, taken from paddr[ADDR_W-1]
    localparam logic REG_DATA_LENGTH = 1'b0;

    // fewest check bits r with 2^r >= r + len + 1
    function automatic logic [CHK_W-1:0] f_check_bits(input logic [LEN_W-1:0] len);
        logic [CHK_W-1:0] r;
        logic             done;
        r    = '0;
        done = 1'b0;
        for (int i = 0; i <= 6; i++) begin
            if (!done && ((8'd1 << i) >= (8'(i) + 8'(len) + 8'd1))) begin
                r    = CHK_W'(i);
                done = 1'b1;
            end
        end
        return r;
    endfunction

    // data bit k goes to the k-th position (from 1) that is not a power of two
    function automatic logic [CODE_W-1:0] f_place(input logic [DATA_W-1:0] data);
        logic [CODE_W-1:0] c;
        int                k;
        c = '0;
        k = 0;
        for (int pos = 1; pos <= CODE_W; pos++) begin
            if ((pos & (pos - 1)) != 0) begin
                if (k < DATA_W) begin
                    c[pos-1] = data[k];
                end
                k++;
            end
        end
        return c;
    endfunction

    // XOR of the position numbers of all set bits
    function automatic logic [POS_W-1:0] f_syndrome(input logic [CODE_W-1:0] w);
        logic [POS_W-1:0] s;
        s = '0;
        for (int j = 0; j < CODE_W; j++) begin
            if (w[j]) begin
                s = s ^ POS_W'(j + 1);
            end
        end
        return s;
    endfunction

endpackage

// ===== rtl/hsec_in_if.sv =====
interface hsec_in_if import hsec_pkg::*;;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_word;
    logic [POS_W-1:0]  error_position;

    modport source (output valid, output data_word, output error_position, input ready);
    modport sink   (input valid, input data_word, input error_position, output ready);
endinterface

// ===== rtl/hsec_out_if.sv =====
interface hsec_out_if import hsec_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] code_word;
    logic [LEN_W-1:0]  code_length;
    logic [CODE_W-1:0] corrupted_word;
    logic [POS_W-1:0]  error_index;
    logic              error_found;
    logic [CODE_W-1:0] corrected_word;
    logic              bad_position;

    modport source (
        output valid, output code_word, output code_length, output corrupted_word,
        output error_index, output error_found, output corrected_word,
        output bad_position, input ready
    );
    modport sink (
        input valid, input code_word, input code_length, input corrupted_word,
        input error_index, input error_found, input corrected_word,
        input bad_position, output ready
    );
endinterface

// ===== rtl/hamming_sec_encode_correct_core.sv =====
// Channel   | Dir | Handshake     | Word
// i_in      | in  | valid / ready | data_word, error_position
// o_out     | out | valid / ready | code_word, code_length, corrupted_word,
//           |     |               | error_index, error_found, corrected_word, bad_position
// APB       | in  | psel/penable  | data_length at byte address 0
//
// One word per cycle while o_out is not stalled; o_out.valid is the registered last stage valid.
// Stages: length/mask, encode XOR tree, error inject, syndrome XOR tree,
// correct into the output register.
// Synchronous active-low reset clears the stage valids and sets data_length to 4.
// Each stage holds while the next one is full and stalled; bubbles collapse,
// so i_in.ready drops only when all five stages are full and o_out is stalled.
module hamming_sec_encode_correct_core import hsec_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    hsec_in_if.sink             i_in,
    hsec_out_if.source          o_out,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    logic [LEN_W-1:0] r_data_length;

    logic             r_v1, r_v2, r_v3, r_v4, r_v5;
    logic             en1, en2, en3, en4, en5;

    // stage 1
    logic [DATA_W-1:0] r_s1_data;
    logic [POS_W-1:0]  r_s1_epos;
    logic [LEN_W-1:0]  r_s1_n;
    logic              r_s1_bad;
    // stage 2
    logic [CODE_W-1:0] r_s2_code;
    logic [POS_W-1:0]  r_s2_epos;
    logic [LEN_W-1:0]  r_s2_n;
    logic              r_s2_bad;
    // stage 3
    logic [CODE_W-1:0] r_s3_code;
    logic [CODE_W-1:0] r_s3_corr;
    logic [LEN_W-1:0]  r_s3_n;
    logic              r_s3_bad;
    // stage 4
    logic [CODE_W-1:0] r_s4_code;
    logic [CODE_W-1:0] r_s4_corr;
    logic [LEN_W-1:0]  r_s4_n;
    logic              r_s4_bad;
    logic [POS_W-1:0]  r_s4_syn;
    // stage 5 (output)
    logic [CODE_W-1:0] r_code_word;
    logic [LEN_W-1:0]  r_code_length;
    logic [CODE_W-1:0] r_corrupted_word;
    logic [POS_W-1:0]  r_error_index;
    logic              r_error_found;
    logic [CODE_W-1:0] r_corrected_word;
    logic              r_bad_position;

    logic [LEN_W-1:0]  n_len;
    logic [LEN_W-1:0]  n_n;
    logic [DATA_W-1:0] n_mask;
    logic [CODE_W-1:0] n_place;
    logic [POS_W-1:0]  n_psyn;
    logic [CODE_W-1:0] n_code;
    logic [CODE_W-1:0] n_corr;
    logic [POS_W-1:0]  n_idx;
    logic              n_found;
    logic [CODE_W-1:0] n_fixed;

    // ---------------- configuration ----------------
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_length <= DATA_LENGTH_RST;
        end else if (psel && penable && pwrite && paddr[ADDR_W-1] == REG_DATA_LENGTH) begin
            r_data_length <= pwdata[LEN_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[ADDR_W-1] == REG_DATA_LENGTH) begin
            prdata = PDATA_W'(r_data_length);
        end
    end

    // ---------------- stall chain ----------------
    assign en5        = !r_v5 || o_out.ready;
    assign en4        = !r_v4 || en5;
    assign en3        = !r_v3 || en4;
    assign en2        = !r_v2 || en3;
    assign en1        = !r_v1 || en2;
    assign i_in.ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_in.valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
        end
    end

    // ---------------- stage 1: length and data mask ----------------
    always_comb begin
        n_len = r_data_length;
        if (r_data_length == '0) begin
            n_len = LEN_W'(1);
        end else if (r_data_length > LEN_W'(DATA_MAX)) begin
            n_len = LEN_W'(DATA_MAX);
        end
        n_n = n_len + LEN_W'(f_check_bits(n_len));
        for (int k = 0; k < DATA_W; k++) begin
            n_mask[k] = (k < int'(n_len));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_data <= i_in.data_word & n_mask;
            r_s1_epos <= i_in.error_position;
            r_s1_n    <= n_n;
            r_s1_bad  <= i_in.error_position >= n_n;
        end
    end

    // ---------------- stage 2: encode ----------------
    // masked data leaves every position above n clear, so parity bits
    // past n come out zero on their own
    always_comb begin
        n_place = f_place(r_s1_data);
        n_psyn  = f_syndrome(n_place);
        n_code  = n_place;
        for (int i = 0; i < POS_W; i++) begin
            n_code[(1 << i) - 1] = n_psyn[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_code <= n_code;
            r_s2_epos <= r_s1_epos;
            r_s2_n    <= r_s1_n;
            r_s2_bad  <= r_s1_bad;
        end
    end

    // ---------------- stage 3: error inject ----------------
    always_comb begin
        n_corr = r_s2_code;
        if (!r_s2_bad) begin
            n_corr = r_s2_code ^ (CODE_W'(1) << r_s2_epos);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_s3_code <= r_s2_code;
            r_s3_corr <= n_corr;
            r_s3_n    <= r_s2_n;
            r_s3_bad  <= r_s2_bad;
        end
    end

    // ---------------- stage 4: syndrome ----------------
    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_s4_code <= r_s3_code;
            r_s4_corr <= r_s3_corr;
            r_s4_n    <= r_s3_n;
            r_s4_bad  <= r_s3_bad;
            r_s4_syn  <= f_syndrome(r_s3_corr);
        end
    end

    // ---------------- stage 5: correct ----------------
    always_comb begin
        n_found = r_s4_syn != '0;
        n_idx   = n_found ? r_s4_syn - POS_W'(1) : '0;
        n_fixed = r_s4_corr;
        // drop the flip if the syndrome points past the word
        if (n_found && n_idx < r_s4_n) begin
            n_fixed = r_s4_corr ^ (CODE_W'(1) << n_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r_code_word      <= r_s4_code;
            r_code_length    <= r_s4_n;
            r_corrupted_word <= r_s4_corr;
            r_error_index    <= n_idx;
            r_error_found    <= n_found;
            r_corrected_word <= n_fixed;
            r_bad_position   <= r_s4_bad;
        end
    end

    assign o_out.valid          = r_v5;
    assign o_out.code_word      = r_code_word;
    assign o_out.code_length    = r_code_length;
    assign o_out.corrupted_word = r_corrupted_word;
    assign o_out.error_index    = r_error_index;
    assign o_out.error_found    = r_error_found;
    assign o_out.corrected_word = r_corrected_word;
    assign o_out.bad_position   = r_bad_position;

endmodule
